### src/spring_force_3d_unit_defines.svh
// Assertion helpers shared by the spring force RTL.
// All assertions sample on clk and are masked while arst_n is low.
`ifndef SPRING_FORCE_3D_UNIT_DEFINES_SVH
`define SPRING_FORCE_3D_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SF3D_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define SF3D_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### src/sf3d_pkg.sv
// ----------------------------------------------------------------------------
// sf3d_pkg
// Shared types and constants for the 3D spring force unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sf3d_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SPRING_CONSTANT = 2'd0,
		REG_REST_LENGTH     = 2'd1
	} cfg_reg_t;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Per-item classification carried alongside the payload
	typedef struct packed {
		logic       bad;    // request names neither end
		logic       degen;  // ends coincide
		logic       right;  // right end requested
		logic [2:0] dneg;   // sign of each difference
	} side_t;

endpackage

`default_nettype wire

### src/spring_force_3d_unit.sv
// Results pass through the bit-per-stage square root and divide pipelines.
// Throughput: one item per cycle; the whole back pipeline stalls only while
// its output register holds an untaken result.
// Reset: arst_n clears all valid state and the queue; spring_constant and
// rest_length return to 1.0.
// ----------------------------------------------------------------------------
// spring_force_3d_unit
// Hooke spring force on one end of a 3D spring, front/queue/back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spring_force_3d_unit_defines.svh"

module spring_force_3d_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [WORD_BITS-1:0]              left_x,
	input  wire logic [WORD_BITS-1:0]              left_y,
	input  wire logic [WORD_BITS-1:0]              left_z,
	input  wire logic [WORD_BITS-1:0]              right_x,
	input  wire logic [WORD_BITS-1:0]              right_y,
	input  wire logic [WORD_BITS-1:0]              right_z,
	input  wire logic [1:0]                        which_end,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [WORD_BITS-1:0]                   force_x,
	output logic [WORD_BITS-1:0]                   force_y,
	output logic [WORD_BITS-1:0]                   force_z,
	output logic                                   bad_end,
	output logic                                   degenerate,
	input  wire logic                              cfg_we,
	input  wire logic [sf3d_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [WORD_BITS-2:0]              cfg_data
);

	localparam int AW = WORD_BITS + 1;
	localparam int DW = $bits(sf3d_pkg::side_t) + 3 * AW;

	logic [WORD_BITS-2:0] spring_constant_q, rest_length_q;

	logic            front_push, fifo_full, fifo_pop, fifo_empty;
	sf3d_pkg::side_t front_side, back_side;
	logic [3*AW-1:0] front_ad, back_ad;
	logic [DW-1:0]   fifo_rdata;
	logic            flagged, force_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_constant_q <= (WORD_BITS-1)'(1) << FRAC_BITS;
			rest_length_q     <= (WORD_BITS-1)'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				sf3d_pkg::REG_SPRING_CONSTANT: spring_constant_q <= cfg_data;
				sf3d_pkg::REG_REST_LENGTH:     rest_length_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	sf3d_front #(.W(WORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_x    (left_x),
		.left_y    (left_y),
		.left_z    (left_z),
		.right_x   (right_x),
		.right_y   (right_y),
		.right_z   (right_z),
		.which_end (which_end),
		.push      (front_push),
		.full      (fifo_full),
		.push_side (front_side),
		.push_ad   (front_ad)
	);

	sf3d_fifo #(.DW(DW), .DEPTH(sf3d_pkg::QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  ({front_side, front_ad}),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.rdata  (fifo_rdata),
		.empty  (fifo_empty)
	);

	assign back_side = fifo_rdata[DW-1 -: $bits(sf3d_pkg::side_t)];
	assign back_ad   = fifo_rdata[3*AW-1:0];

	sf3d_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop             (fifo_pop),
		.empty           (fifo_empty),
		.pop_side        (back_side),
		.pop_ad          (back_ad),
		.spring_constant (spring_constant_q),
		.rest_length     (rest_length_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.force_x         (force_x),
		.force_y         (force_y),
		.force_z         (force_z),
		.bad_end         (bad_end),
		.degenerate      (degenerate)
	);

	assign flagged    = bad_end || degenerate;
	assign force_zero = (force_x == '0) && (force_y == '0) && (force_z == '0);

	`SF3D_ASSERT_IMP(a_flags_exclusive, out_valid, !(bad_end && degenerate), "both flags set")
	`SF3D_ASSERT_IMP(a_flag_zero_force, out_valid && flagged, force_zero, "flag with force")
	`SF3D_ASSERT_NEXT(a_queue_full_holds, fifo_full && !fifo_pop, fifo_full, "full without pop")

endmodule

`default_nettype wire

### src/sf3d_front.sv
// ----------------------------------------------------------------------------
// sf3d_front
// Accepts items, forms the endpoint differences and their magnitudes,
// classifies the request and pushes the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3d_front #(
	parameter int W = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [W-1:0]         left_x,
	input  wire logic [W-1:0]         left_y,
	input  wire logic [W-1:0]         left_z,
	input  wire logic [W-1:0]         right_x,
	input  wire logic [W-1:0]         right_y,
	input  wire logic [W-1:0]         right_z,
	input  wire logic [1:0]           which_end,
	output logic                      push,
	input  wire logic                 full,
	output sf3d_pkg::side_t           push_side,
	output logic [3*(W+1)-1:0]        push_ad
);

	localparam int AW = W + 1;

	logic [AW-1:0] d   [3];
	logic [AW-1:0] mag [3];
	logic          v_s1;
	sf3d_pkg::side_t side_s1;
	logic [3*AW-1:0] ad_s1;

	// sign-extended differences, right minus left
	assign d[0] = {right_x[W-1], right_x} - {left_x[W-1], left_x};
	assign d[1] = {right_y[W-1], right_y} - {left_y[W-1], left_y};
	assign d[2] = {right_z[W-1], right_z} - {left_z[W-1], left_z};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = d[i][AW-1] ? (~d[i] + AW'(1)) : d[i];
		end
	end

	assign in_ready = !v_s1 || !full;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			side_s1.bad   <= which_end[1];
			side_s1.degen <= (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
			side_s1.right <= (which_end == 2'd1);
			side_s1.dneg  <= {d[2][AW-1], d[1][AW-1], d[0][AW-1]};
			ad_s1         <= {mag[2], mag[1], mag[0]};
		end
	end

	assign push_side = side_s1;
	assign push_ad   = ad_s1;

endmodule

`default_nettype wire

### src/sf3d_fifo.sv
// ----------------------------------------------------------------------------
// sf3d_fifo
// Small register queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3d_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] wdata,
	output logic               full,
	input  wire logic          pop,
	output logic [DW-1:0]      rdata,
	output logic               empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### src/sf3d_sqrt.sv
// ----------------------------------------------------------------------------
// sf3d_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3d_sqrt #(
	parameter int SW = 68,
	parameter int RW = 34
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [SW-1:0] x,
	output logic [RW-1:0]      root
);

	logic [SW-1:0] rem_s  [1:RW];
	logic [RW-1:0] root_s [1:RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int B = RW - 1 - i;
		logic [SW-1:0] rin, trial;
		logic [RW-1:0] rtin;

		if (i == 0) begin : g_first
			assign rin  = x;
			assign rtin = '0;
		end else begin : g_next
			assign rin  = rem_s[i];
			assign rtin = root_s[i];
		end

		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B), compared against x - r^2
		assign trial = (SW'(rtin) << (B + 1)) | (SW'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rin >= trial) begin
					rem_s[i+1]  <= rin - trial;
					root_s[i+1] <= rtin | (RW'(1) << B);
				end else begin
					rem_s[i+1]  <= rin;
					root_s[i+1] <= rtin;
				end
			end
		end
	end

	assign root = root_s[RW];

endmodule

`default_nettype wire

### src/sf3d_div.sv
// ----------------------------------------------------------------------------
// sf3d_div
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3d_div #(
	parameter int NW  = 49,
	parameter int DNW = 34,
	parameter int QW  = 17
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [NW-1:0]  num,
	input  wire logic [DNW-1:0] den,
	output logic [QW-1:0]       quo
);

	localparam int RMW = DNW + QW;

	logic [RMW-1:0] rem_s [1:QW];
	logic [DNW-1:0] den_s [1:QW];
	logic [QW-1:0]  q_s   [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int K = QW - 1 - i;
		logic [RMW-1:0] rin, dsh;
		logic [DNW-1:0] din;
		logic [QW-1:0]  qin;

		if (i == 0) begin : g_first
			assign rin = RMW'(num);
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[i];
			assign din = den_s[i];
			assign qin = q_s[i];
		end

		assign dsh = RMW'(din) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= din;
				if (rin >= dsh) begin
					rem_s[i+1] <= rin - dsh;
					q_s[i+1]   <= qin | (QW'(1) << K);
				end else begin
					rem_s[i+1] <= rin;
					q_s[i+1]   <= qin;
				end
			end
		end
	end

	assign quo = q_s[QW];

endmodule

`default_nettype wire

### src/sf3d_back.sv
// ----------------------------------------------------------------------------
// sf3d_back
// Force pipeline: squares, sum, square root, stretch, spring product,
// unit direction divides, force product, saturation and output register.
// The whole pipeline advances when its output register is free or taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sf3d_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	output logic                      pop,
	input  wire logic                 empty,
	input  wire sf3d_pkg::side_t      pop_side,
	input  wire logic [3*(W+1)-1:0]   pop_ad,
	input  wire logic [W-2:0]         spring_constant,
	input  wire logic [W-2:0]         rest_length,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [W-1:0]              force_x,
	output logic [W-1:0]              force_y,
	output logic [W-1:0]              force_z,
	output logic                      bad_end,
	output logic                      degenerate
);

	localparam int AW  = W + 1;             // difference magnitude
	localparam int SW  = 2 * AW + 2;        // sum of squares
	localparam int RW  = SW / 2;            // length
	localparam int SBW = (W - 1) + RW - F;  // scaled stretch
	localparam int QW  = F + 1;             // unit direction component
	localparam int P   = RW + 3;            // position of length/stretch regs
	localparam int Q   = P + F + 2;         // position of force products
	localparam int N   = Q + 1;             // output register position

	logic en;

	logic              v_s    [1:N];
	sf3d_pkg::side_t   side_s [1:Q];
	logic [3*AW-1:0]   ad_s   [1:P];
	logic              sneg_s [P:Q];

	logic [2*AW-1:0]   sq_s1 [3];
	logic [SW-1:0]     sum_s2;
	logic [RW-1:0]     root;
	logic [RW-1:0]     dist_s3, smag_s3;
	logic              sneg;
	logic [SBW-1:0]    sprod_s4;
	logic [SBW-1:0]    sdly_s [1:F];
	logic [QW-1:0]     u [3];
	logic [SBW+QW-1:0] force_s5 [3];
	logic [W-1:0]      sat [3];
	logic [W-1:0]      fx_s6, fy_s6, fz_s6;
	logic              bad_s6, degen_s6;
	logic [(W-1)+RW-1:0] kprod;

	assign en        = !v_s[N] || out_ready;
	assign pop       = en && !empty;
	assign out_valid = v_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= N; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= !empty;
			for (int k = 2; k <= N; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	// sideband lines
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= pop_side;
			for (int k = 2; k <= Q; k++) begin
				side_s[k] <= side_s[k-1];
			end
			ad_s[1] <= pop_ad;
			for (int k = 2; k <= P; k++) begin
				ad_s[k] <= ad_s[k-1];
			end
			sneg_s[P] <= sneg;
			for (int k = P + 1; k <= Q; k++) begin
				sneg_s[k] <= sneg_s[k-1];
			end
		end
	end

	// squares and sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= (2*AW)'(pop_ad[i*AW +: AW]) * (2*AW)'(pop_ad[i*AW +: AW]);
			end
			sum_s2 <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
		end
	end

	sf3d_sqrt #(.SW(SW), .RW(RW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (sum_s2),
		.root (root)
	);

	// stretch = length - rest length, kept as sign and magnitude
	assign sneg = (root < RW'(rest_length));

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s3 <= root;
			smag_s3 <= sneg ? (RW'(rest_length) - root) : (root - RW'(rest_length));
		end
	end

	assign kprod = ((W-1)+RW)'(spring_constant) * ((W-1)+RW)'(smag_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			sprod_s4  <= kprod[(W-1)+RW-1:F];
			sdly_s[1] <= sprod_s4;
			for (int k = 2; k <= F; k++) begin
				sdly_s[k] <= sdly_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		sf3d_div #(.NW(AW + F), .DNW(RW), .QW(QW)) u_div (
			.clk (clk),
			.en  (en),
			.num ({ad_s[P][i*AW +: AW], {F{1'b0}}}),
			.den (dist_s3),
			.quo (u[i])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				force_s5[i] <= (SBW+QW)'(sdly_s[F]) * (SBW+QW)'(u[i]);
			end
		end
	end

	// shift out the fraction, apply sign, saturate
	always_comb begin
		logic [SBW:0] fsh;
		logic         neg;
		for (int i = 0; i < 3; i++) begin
			fsh = force_s5[i][SBW+QW-1:F];
			neg = (sneg_s[Q] != side_s[Q].dneg[i]) != side_s[Q].right;
			if (neg) begin
				if (fsh >= ((SBW+1)'(1) << (W - 1))) begin
					sat[i] = {1'b1, {(W-1){1'b0}}};
				end else begin
					sat[i] = ~fsh[W-1:0] + W'(1);
				end
			end else begin
				if (fsh >= ((SBW+1)'(1) << (W - 1))) begin
					sat[i] = {1'b0, {(W-1){1'b1}}};
				end else begin
					sat[i] = fsh[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s6   <= side_s[Q].bad;
			degen_s6 <= !side_s[Q].bad && side_s[Q].degen;
			if (side_s[Q].bad || side_s[Q].degen) begin
				fx_s6 <= '0;
				fy_s6 <= '0;
				fz_s6 <= '0;
			end else begin
				fx_s6 <= sat[0];
				fy_s6 <= sat[1];
				fz_s6 <= sat[2];
			end
		end
	end

	assign force_x    = fx_s6;
	assign force_y    = fy_s6;
	assign force_z    = fz_s6;
	assign bad_end    = bad_s6;
	assign degenerate = degen_s6;

endmodule

`default_nettype wire
